>>> rtl/efsa_pkg.sv
package efsa_pkg;

  // default number of servers
  localparam int unsigned MAX_SERVERS_DEF = 8;
  // chosen_server is three bits wide, so at most eight servers can be picked
  localparam int unsigned INDEX_LIMIT = 8;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned SPAN_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_SERVE   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // search packet handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] fin;
    logic [IDX_W-1:0]  idx;
  } pkt_t;

  // control broadcast to every cell
  typedef struct packed {
    logic              clear;
    logic              ld;
    logic [IDX_W-1:0]  ld_slot;
    logic [SPAN_W-1:0] ld_time;
    logic              upd;
    logic [IDX_W-1:0]  upd_idx;
    logic [TIME_W-1:0] upd_fin;
    logic [CNT_W-1:0]  active_n;
  } ctl_t;

endpackage

>>> rtl/efsa_cell.sv
module efsa_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  efsa_pkg::ctl_t ctl_i,
  input  efsa_pkg::pkt_t pkt_i,
  output efsa_pkg::pkt_t pkt_o
);

  logic [efsa_pkg::TIME_W-1:0] nf_q, nf_d;
  logic [efsa_pkg::SPAN_W-1:0] st_q, st_d;
  logic                        pv_q;
  logic [efsa_pkg::TIME_W-1:0] pfin_q, pfin_d;
  logic [efsa_pkg::IDX_W-1:0]  pidx_q, pidx_d;
  logic [efsa_pkg::TIME_W:0]   sum;
  logic [efsa_pkg::TIME_W-1:0] fin;
  logic                        active;
  logic                        take;

  // saturated finish time of this server
  assign sum = {1'b0, nf_q} + {{(efsa_pkg::TIME_W + 1 - efsa_pkg::SPAN_W){1'b0}}, st_q};
  assign fin = sum[efsa_pkg::TIME_W] ? {efsa_pkg::TIME_W{1'b1}} : sum[efsa_pkg::TIME_W-1:0];

  // first cell always takes the request, later ones only on a strictly smaller finish
  assign active = (efsa_pkg::CNT_W'(CELL_IDX) < ctl_i.active_n);
  assign take   = pkt_i.valid && active && ((CELL_IDX == 0) || (fin < pkt_i.fin));

  always_comb begin
    pfin_d = take ? fin : pkt_i.fin;
    pidx_d = take ? efsa_pkg::IDX_W'(CELL_IDX) : pkt_i.idx;
  end

  // server state updates
  always_comb begin
    nf_d = nf_q;
    st_d = st_q;
    if (ctl_i.clear) begin
      nf_d = '0;
    end else if (ctl_i.upd && (ctl_i.upd_idx == efsa_pkg::IDX_W'(CELL_IDX))) begin
      nf_d = ctl_i.upd_fin;
    end
    if (ctl_i.ld && (ctl_i.ld_slot == efsa_pkg::IDX_W'(CELL_IDX))) begin
      st_d = ctl_i.ld_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q <= '0;
      st_q <= '0;
      pv_q <= 1'b0;
    end else begin
      nf_q <= nf_d;
      st_q <= st_d;
      pv_q <= pkt_i.valid;
    end
  end

  // packet payload to the neighbor
  always_ff @(posedge clk_i) begin
    pfin_q <= pfin_d;
    pidx_q <= pidx_d;
  end

  assign pkt_o = '{valid: pv_q, fin: pfin_q, idx: pidx_q};

endmodule

>>> rtl/earliest_finish_server_assigner_top.sv
// Earliest-finish server assigner.
// Input channel (in_valid_i / in_stall_o) carries one request: cmd_i,
// server_slot_i and service_time_i. A load request sets one server's service
// time, a restart request clears every next-free time, a serve request picks
// the server with the least saturated next-free plus service time (ties to the
// lowest index) and returns finish_time_o / chosen_server_o on the output
// channel (out_valid_o / out_stall_i).
// Servers sit in a row of cells; a serve request walks the row one cell per
// cycle, its result is registered at the end of the row and then moved into
// the output register, and the next request is taken once it is there. Load
// and restart requests complete in the accepting cycle. servers_in_use is
// written through cfg_we_i / cfg_wdata_i; the user must write it only while
// idle, the block does not enforce this. 0 acts as 1, values above the server
// count saturate. Reset clears all next-free and service times, sets
// servers_in_use to 1 and empties the output register.
// A result waiting under out_stall_i holds its value; loads and restarts are
// still taken meanwhile, and a further serve waits at the end of its walk
// until the output register is free.
module earliest_finish_server_assigner_top #(
  parameter int unsigned MAX_SERVERS = efsa_pkg::MAX_SERVERS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [efsa_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [efsa_pkg::CMD_W-1:0]  cmd_i,
  input  logic [efsa_pkg::IDX_W-1:0]  server_slot_i,
  input  logic [efsa_pkg::SPAN_W-1:0] service_time_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [efsa_pkg::TIME_W-1:0] finish_time_o,
  output logic [efsa_pkg::IDX_W-1:0]  chosen_server_o
);

  localparam int unsigned NumCells =
    (MAX_SERVERS < efsa_pkg::INDEX_LIMIT) ? MAX_SERVERS : efsa_pkg::INDEX_LIMIT;

  efsa_pkg::state_e            state_q, state_d;
  logic [efsa_pkg::CNT_W-1:0]  use_q;
  logic [efsa_pkg::CNT_W-1:0]  active_n;
  logic                        accept;
  logic                        is_serve;
  logic                        tail_done;
  logic                        out_load;
  logic [efsa_pkg::TIME_W-1:0] res_fin_q;
  logic [efsa_pkg::IDX_W-1:0]  res_idx_q;
  logic                        out_valid_q;
  logic [efsa_pkg::TIME_W-1:0] out_fin_q;
  logic [efsa_pkg::IDX_W-1:0]  out_idx_q;
  logic [NumCells-1:0]         chain_valid;
  efsa_pkg::ctl_t              ctl;
  efsa_pkg::pkt_t              chain [NumCells+1];

  assign accept    = in_valid_i && !in_stall_o;
  assign is_serve  = (cmd_i == efsa_pkg::CMD_SERVE);
  assign tail_done = chain[NumCells].valid;

  // servers_in_use register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= efsa_pkg::CNT_W'(1);
    end else if (cfg_we_i) begin
      use_q <= cfg_wdata_i;
    end
  end

  // effective server count
  always_comb begin
    active_n = use_q;
    if (use_q == '0) begin
      active_n = efsa_pkg::CNT_W'(1);
    end else if (use_q > efsa_pkg::CNT_W'(NumCells)) begin
      active_n = efsa_pkg::CNT_W'(NumCells);
    end
  end

  // control broadcast
  always_comb begin
    ctl.clear    = accept && (cmd_i == efsa_pkg::CMD_RESTART);
    ctl.ld       = accept && (cmd_i == efsa_pkg::CMD_LOAD);
    ctl.ld_slot  = server_slot_i;
    ctl.ld_time  = service_time_i;
    ctl.upd      = tail_done;
    ctl.upd_idx  = chain[NumCells].idx;
    ctl.upd_fin  = chain[NumCells].fin;
    ctl.active_n = active_n;
  end

  // serve request enters the first cell
  assign chain[0] = '{valid: accept && is_serve, fin: '0, idx: '0};

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    efsa_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .pkt_i (chain[g]),
      .pkt_o (chain[g+1])
    );
    assign chain_valid[g] = chain[g+1].valid;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    case (state_q)
      efsa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && is_serve) begin
          state_d = efsa_pkg::ST_SCAN;
        end
      end
      efsa_pkg::ST_SCAN: begin
        if (tail_done) begin
          state_d = efsa_pkg::ST_DONE;
        end
      end
      efsa_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = efsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = efsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= efsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // result of the walk
  always_ff @(posedge clk_i) begin
    if (tail_done) begin
      res_fin_q <= chain[NumCells].fin;
      res_idx_q <= chain[NumCells].idx;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_fin_q <= res_fin_q;
      out_idx_q <= res_idx_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign finish_time_o   = out_fin_q;
  assign chosen_server_o = out_idx_q;

`ifndef SYNTHESIS
  a_one_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_valid))
    else $error("more than one serve request in the cell row");

  a_walk_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid != '0) |-> (state_q == efsa_pkg::ST_SCAN))
    else $error("serve request in the cell row outside scan");

  a_serve_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_serve) |=> (state_q == efsa_pkg::ST_SCAN))
    else $error("accepted serve request did not start a scan");

  a_chosen_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(cfg_we_i)) |->
      ({1'b0, chosen_server_o} < active_n))
    else $error("chosen server outside the servers in use");
`endif

endmodule

>>> sim/earliest_finish_server_assigner_checker.sv
`timescale 1ns / 1ps

module earliest_finish_server_assigner_checker #(
  parameter int unsigned MAX_SERVERS = efsa_pkg::MAX_SERVERS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [efsa_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [efsa_pkg::CMD_W-1:0]  cmd_i,
  input  logic [efsa_pkg::IDX_W-1:0]  server_slot_i,
  input  logic [efsa_pkg::SPAN_W-1:0] service_time_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [efsa_pkg::TIME_W-1:0] finish_time_i,
  input  logic [efsa_pkg::IDX_W-1:0]  chosen_server_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [efsa_pkg::TIME_W-1:0] finish;
    logic [efsa_pkg::IDX_W-1:0]  server;
  } assignment_t;

  // shadow of the server row
  logic [efsa_pkg::TIME_W-1:0] free_at [MAX_SERVERS];
  logic [efsa_pkg::SPAN_W-1:0] span_of [MAX_SERVERS];
  logic [efsa_pkg::CNT_W-1:0]  servers_cfg;
  assignment_t                 due_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  // least saturated next-free plus service time, ties to the lowest index
  function automatic assignment_t earliest_finish();
    int unsigned                 n;
    int unsigned                 cap;
    logic [efsa_pkg::TIME_W:0]   sum;
    logic [efsa_pkg::TIME_W-1:0] fin;
    assignment_t                 best;
    cap = (MAX_SERVERS < efsa_pkg::INDEX_LIMIT) ? MAX_SERVERS : efsa_pkg::INDEX_LIMIT;
    n = servers_cfg;
    if (n == 0) n = 1;
    if (n > cap) n = cap;
    best = '0;
    for (int unsigned i = 0; i < n; i++) begin
      sum = {1'b0, free_at[i]} +
            {{(efsa_pkg::TIME_W + 1 - efsa_pkg::SPAN_W){1'b0}}, span_of[i]};
      fin = sum[efsa_pkg::TIME_W] ? {efsa_pkg::TIME_W{1'b1}} : sum[efsa_pkg::TIME_W-1:0];
      if (i == 0 || fin < best.finish) begin
        best.finish = fin;
        best.server = efsa_pkg::IDX_W'(i);
      end
    end
    return best;
  endfunction

  always @(posedge clk_i) begin
    assignment_t pick;
    assignment_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SERVERS; i++) begin
        free_at[i] = '0;
        span_of[i] = '0;
      end
      servers_cfg = efsa_pkg::CNT_W'(1);
      due_q.delete();
    end else begin
      if (cfg_we_i) begin
        servers_cfg = cfg_wdata_i;
      end

      // compare each taken result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("result %h/%0d with none expected",
                                    finish_time_i, chosen_server_i));
        end else begin
          want = due_q.pop_front();
          if (finish_time_i !== want.finish) begin
            report_mismatch($sformatf("finish_time %h, expected %h",
                                      finish_time_i, want.finish));
          end
          if (chosen_server_i !== want.server) begin
            report_mismatch($sformatf("chosen_server %0d, expected %0d",
                                      chosen_server_i, want.server));
          end
        end
      end

      // update the shadow on each taken request
      if (in_valid_i && !in_stall_i) begin
        case (cmd_i)
          efsa_pkg::CMD_LOAD: begin
            if (server_slot_i < MAX_SERVERS) span_of[server_slot_i] = service_time_i;
          end
          efsa_pkg::CMD_SERVE: begin
            pick = earliest_finish();
            free_at[pick.server] = pick.finish;
            due_q.push_back(pick);
          end
          efsa_pkg::CMD_RESTART: begin
            for (int i = 0; i < MAX_SERVERS; i++) free_at[i] = '0;
          end
          default: ;
        endcase
      end
    end
    pending_o <= due_q.size();
  end

endmodule

>>> sim/earliest_finish_server_assigner_top_tb.sv
`timescale 1ns / 1ps

module earliest_finish_server_assigner_top_tb;

  localparam int unsigned SERVERS = efsa_pkg::MAX_SERVERS_DEF;
  localparam logic [efsa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  // back to back serves on one server at the largest span
  localparam int TOP_SERVES = 12;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_we_i       = 1'b0;
  logic [efsa_pkg::CNT_W-1:0]  cfg_wdata_i    = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic [efsa_pkg::CMD_W-1:0]  cmd_i          = efsa_pkg::CMD_LOAD;
  logic [efsa_pkg::IDX_W-1:0]  server_slot_i  = '0;
  logic [efsa_pkg::SPAN_W-1:0] service_time_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic [efsa_pkg::TIME_W-1:0] finish_time_o;
  logic [efsa_pkg::IDX_W-1:0]  chosen_server_o;

  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;
  int   stall_left  = 0;
  int   next_stall;
  logic quiet_q     = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  earliest_finish_server_assigner_top #(
    .MAX_SERVERS(SERVERS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .server_slot_i  (server_slot_i),
    .service_time_i (service_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .finish_time_o  (finish_time_o),
    .chosen_server_o(chosen_server_o)
  );

  earliest_finish_server_assigner_checker #(
    .MAX_SERVERS(SERVERS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .cmd_i          (cmd_i),
    .server_slot_i  (server_slot_i),
    .service_time_i (service_time_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .finish_time_i  (finish_time_o),
    .chosen_server_i(chosen_server_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count)
  );

  // result side: each result is held for a random number of cycles
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      next_stall = quiet_q ? 0 : $urandom_range(0, 3);
      stall_left  <= next_stall;
      out_stall_i <= (next_stall != 0);
    end else if (stall_left != 0 && out_valid_o) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one request after a random gap, held until taken
  task automatic push_request(input logic [efsa_pkg::CMD_W-1:0] cmd,
                              input logic [efsa_pkg::IDX_W-1:0] slot,
                              input logic [efsa_pkg::SPAN_W-1:0] span);
    int gap;
    gap = quiet_q ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    server_slot_i  <= slot;
    service_time_i <= span;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop sending and wait until every result is back and the row is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_servers(input logic [efsa_pkg::CNT_W-1:0] count);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [efsa_pkg::SPAN_W-1:0] random_span();
    case ($urandom_range(0, 3))
      0:       return efsa_pkg::SPAN_W'($urandom_range(0, 3));
      1:       return {efsa_pkg::SPAN_W{1'b1}};
      default: return efsa_pkg::SPAN_W'($urandom);
    endcase
  endfunction

  task automatic random_request(output bit counted);
    logic [efsa_pkg::CMD_W-1:0] cmd;
    int                         roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      cmd = efsa_pkg::CMD_SERVE;
    else if (roll < 80) cmd = efsa_pkg::CMD_LOAD;
    else if (roll < 90) cmd = efsa_pkg::CMD_RESTART;
    else                cmd = CMD_UNUSED;
    push_request(cmd, efsa_pkg::IDX_W'($urandom), random_span());
    counted = (cmd != CMD_UNUSED);
  endtask

  initial begin
    bit counted;
    int taken;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one server after reset, nothing loaded yet
    push_request(efsa_pkg::CMD_SERVE, 3'd5, 16'h1234);
    push_request(CMD_UNUSED, 3'd7, {efsa_pkg::SPAN_W{1'b1}});
    push_request(efsa_pkg::CMD_LOAD, 3'd7, {efsa_pkg::SPAN_W{1'b1}});
    push_request(efsa_pkg::CMD_LOAD, 3'd0, 16'd0);
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);

    // all eight servers, mostly unloaded, with ties
    set_servers(efsa_pkg::CNT_W'(8));
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);
    push_request(efsa_pkg::CMD_LOAD, 3'd0, 16'd100);
    push_request(efsa_pkg::CMD_LOAD, 3'd1, 16'd50);
    push_request(efsa_pkg::CMD_LOAD, 3'd2, 16'd50);
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);
    push_request(efsa_pkg::CMD_RESTART, 3'd3, 16'h5555);
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);

    // zero acts as one, fifteen saturates at the server count
    set_servers(efsa_pkg::CNT_W'(0));
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);
    set_servers({efsa_pkg::CNT_W{1'b1}});
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);

    // one server at the largest span, requests back to back
    set_servers(efsa_pkg::CNT_W'(1));
    quiet_q <= 1'b1;
    push_request(efsa_pkg::CMD_RESTART, 3'd0, 16'd0);
    push_request(efsa_pkg::CMD_LOAD, 3'd1, 16'd7);
    push_request(efsa_pkg::CMD_LOAD, 3'd0, {efsa_pkg::SPAN_W{1'b1}});
    for (int i = 0; i < TOP_SERVES; i++) begin
      push_request(efsa_pkg::CMD_SERVE, efsa_pkg::IDX_W'(i), efsa_pkg::SPAN_W'(i));
    end
    push_request(efsa_pkg::CMD_LOAD, 3'd0, 16'd0);
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);
    quiet_q <= 1'b0;
    set_servers(efsa_pkg::CNT_W'(2));
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);
    push_request(efsa_pkg::CMD_SERVE, 3'd0, 16'd0);

    // random phases, each under its own server count
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_servers(efsa_pkg::CNT_W'(8));
        1:       set_servers({efsa_pkg::CNT_W{1'b1}});
        2:       set_servers(efsa_pkg::CNT_W'(0));
        3:       set_servers(efsa_pkg::CNT_W'(3));
        default: set_servers(efsa_pkg::CNT_W'($urandom_range(0, 15)));
      endcase
      quiet_q <= (phase == 3);
      push_request(efsa_pkg::CMD_RESTART, efsa_pkg::IDX_W'($urandom),
                   efsa_pkg::SPAN_W'($urandom));
      taken = 0;
      while (taken < 75) begin
        random_request(counted);
        if (counted) taken++;
        if (phase == 1 && taken == 40) settle();
      end
    end

    settle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
